@@ src/sps_pkg.sv @@
// Shared types, codes, constants and coil tables of the stepper phase sequencer.
`default_nettype none

package sps_pkg;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned SPEED_W    = 8;
    localparam int unsigned COIL_W     = 4;
    localparam int unsigned PHASE_W    = 4;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned SPR_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Period numerator in 100 us ticks, and the divider built around it
    localparam int unsigned NUM_W      = 20;
    localparam logic [NUM_W-1:0] PERIOD_NUM = 20'd600000;
    localparam int unsigned DIVISOR_W  = SPR_W + SPEED_W;
    localparam int unsigned DIV_STEPS  = NUM_W;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAVE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FULL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BIPOLAR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 2'd1;

    localparam logic [MODE_W-1:0] DRIVE_MODE_RST    = MODE_WAVE;
    localparam logic [SPR_W-1:0]  STEPS_PER_REV_RST = 16'd2048;

    localparam logic [PHASE_W-1:0] PHASE_UP_START   = 4'd15;
    localparam logic [PHASE_W-1:0] PHASE_DOWN_FOUR  = 4'd4;
    localparam logic [PHASE_W-1:0] PHASE_DOWN_EIGHT = 4'd8;
    localparam logic [PHASE_W-1:0] LAST_FOUR        = 4'd3;
    localparam logic [PHASE_W-1:0] LAST_EIGHT       = 4'd7;

    localparam logic [COIL_W-1:0] COILS_OFF = 4'h0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FINISH
    } sps_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic finish;
    } sps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_start;
        logic out_free;
    } sps_status_t;

    // New coil pattern for a phase; keep the current one when the phase is off the table
    function automatic logic [COIL_W-1:0] coil_lookup(
        input logic [MODE_W-1:0]  mode,
        input logic [PHASE_W-1:0] phase,
        input logic [COIL_W-1:0]  cur
    );
        logic [COIL_W-1:0] pat;
        pat = cur;
        if (mode == MODE_HALF) begin
            case (phase)
                4'd0:    pat = 4'h9;
                4'd1:    pat = 4'h1;
                4'd2:    pat = 4'h3;
                4'd3:    pat = 4'h2;
                4'd4:    pat = 4'h6;
                4'd5:    pat = 4'h4;
                4'd6:    pat = 4'hC;
                4'd7:    pat = 4'h8;
                default: pat = cur;
            endcase
        end else if (phase < 4'd4) begin
            case (mode)
                MODE_WAVE:
                begin
                    case (phase[1:0])
                        2'd0:    pat = 4'h1;
                        2'd1:    pat = 4'h2;
                        2'd2:    pat = 4'h4;
                        default: pat = 4'h8;
                    endcase
                end
                MODE_FULL:
                begin
                    case (phase[1:0])
                        2'd0:    pat = 4'h9;
                        2'd1:    pat = 4'h3;
                        2'd2:    pat = 4'h6;
                        default: pat = 4'hC;
                    endcase
                end
                MODE_BIPOLAR:
                begin
                    case (phase[1:0])
                        2'd0:    pat = 4'hA;
                        2'd1:    pat = 4'h6;
                        2'd2:    pat = 4'h5;
                        default: pat = 4'h9;
                    endcase
                end
                default: pat = cur;
            endcase
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

@@ src/sps_if.sv @@
// Channel interfaces of the stepper phase sequencer: command, result and register write.
`default_nettype none

interface sps_in_if;
    logic                        valid;
    logic                        ready;
    logic [sps_pkg::OP_W-1:0]    op;
    logic [sps_pkg::COUNT_W-1:0] step_count;
    logic [sps_pkg::SPEED_W-1:0] speed;
    logic                        clockwise;

    modport source (output valid, output op, output step_count, output speed,
                    output clockwise, input ready);
    modport sink   (input valid, input op, input step_count, input speed,
                    input clockwise, output ready);
endinterface

interface sps_out_if;
    logic                        valid;
    logic                        ready;
    logic [sps_pkg::COIL_W-1:0]  coils;
    logic [sps_pkg::COUNT_W-1:0] steps_left;
    logic                        stepped;
    logic                        busy_res;

    modport source (output valid, output coils, output steps_left, output stepped,
                    output busy_res, input ready);
    modport sink   (input valid, input coils, input steps_left, input stepped,
                    input busy_res, output ready);
endinterface

interface sps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sps_pkg::CFG_IDX_W-1:0]  index;
    logic [sps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/stepper_phase_sequencer.sv @@
// Top level of the stepper phase sequencer: controller and datapath joined by command and status.
//
//  channel  dir  handshake     payload
//  cmd      in   valid/ready   op, step_count, speed, clockwise
//  res      out  valid/ready   coils, steps_left, stepped, busy_res
//  cfg      in   valid/ready   index (0 drive_mode, 1 steps_per_rev), data
//
// Tick, stop and unknown items end at their transfer, where the result is registered.
// A start item computes 600000 / (steps_per_rev * speed) in a restoring divider that
// resolves one quotient bit per cycle for each numerator bit, then passes a finish state.
// One item is in work at a time; a result waiting in the result register holds the input
// off until it transfers, and holds the finish cycle of a start item the same way.
// cfg is always ready; rst_n clears all motion state and restores the register defaults.
`default_nettype none

module stepper_phase_sequencer (
    input  wire logic clk,
    input  wire logic rst_n,
    sps_in_if.sink    cmd,
    sps_out_if.source res,
    sps_cfg_if.sink   cfg
);
    import sps_pkg::*;

    sps_cmd_t    ctl;
    sps_status_t st;
    logic        in_ready;

    assign cmd.ready = in_ready;

    sps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    sps_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg),
        .ctl   (ctl),
        .st    (st)
    );

endmodule

`default_nettype wire

@@ src/sps_ctrl.sv @@
// Controller of the stepper phase sequencer: item intake and period divide sequencing.
`default_nettype none

module sps_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sps_pkg::sps_status_t st,
    output sps_pkg::sps_cmd_t         ctl
);
    import sps_pkg::*;

    sps_state_t           state_reg;
    sps_state_t           state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic                 accept;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                div_cnt_next = '0;
                if (accept && st.op_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the result register can take the start result
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctl.accept   = 1'b0;
        ctl.div_step = 1'b0;
        ctl.finish   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = st.out_free;
                ctl.accept = in_valid && st.out_free;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            S_FINISH:
            begin
                ctl.finish = st.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = ctl.accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");

    a_div_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_cnt_reg <= DIV_LAST)
        else $error("divide step count out of range");

    a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && st.out_free) |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");

    a_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && st.op_start) |=> (state_reg == S_DIV && div_cnt_reg == '0))
        else $error("start transfer did not begin the divide");

endmodule

`default_nettype wire

@@ src/sps_datapath.sv @@
// Datapath of the stepper phase sequencer: motion state, period divider, result register.
`default_nettype none

module sps_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    sps_in_if.sink                  cmd,
    sps_out_if.source               res,
    sps_cfg_if.sink                 cfg,
    input  wire sps_pkg::sps_cmd_t  ctl,
    output sps_pkg::sps_status_t    st
);
    import sps_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic [SPR_W-1:0]     spr_reg;
    logic [PERIOD_W-1:0]  period_reg,   period_next;
    logic [PERIOD_W-1:0]  cd_reg,       cd_next;
    logic [COUNT_W-1:0]   steps_reg,    steps_next;
    logic [PHASE_W-1:0]   phase_reg,    phase_next;
    logic                 count_up_reg, count_up_next;
    logic [COIL_W-1:0]    coil_reg,     coil_next;

    logic [DIVISOR_W-1:0] divisor_reg,  divisor_next;
    logic [DIVISOR_W-1:0] rem_reg,      rem_next;
    logic [NUM_W-1:0]     num_reg,      num_next;
    logic [NUM_W-1:0]     quo_reg,      quo_next;

    logic                 res_valid_reg, res_valid_next;
    logic [COIL_W-1:0]    res_coils_reg;
    logic [COUNT_W-1:0]   res_steps_reg;
    logic                 res_stepped_reg;
    logic                 res_busy_reg;

    logic                 load_res;
    logic                 stepped_now;

    logic [PERIOD_W-1:0]  cd_dec;
    logic [COUNT_W-1:0]   steps_dec;
    logic [PHASE_W-1:0]   last_phase;
    logic [PHASE_W-1:0]   phase_up;
    logic [PHASE_W-1:0]   phase_step;
    logic                 tick_live;
    logic                 tick_fire;
    logic [SPR_W-1:0]     spr_eff;
    logic [SPEED_W-1:0]   speed_eff;
    logic [DIVISOR_W:0]   rem_shift;
    logic [PERIOD_W-1:0]  q_sat;

    assign cfg.ready = 1'b1;

    assign st.op_start = (cmd.op == OP_START);
    assign st.out_free = !res_valid_reg || res.ready;

    // Tick arithmetic
    always_comb
    begin
        cd_dec     = cd_reg - 1'b1;
        steps_dec  = steps_reg - 1'b1;
        last_phase = (mode_reg == MODE_HALF) ? LAST_EIGHT : LAST_FOUR;
        phase_up   = phase_reg + 1'b1;
        tick_live  = (mode_reg != MODE_NONE) && (steps_reg != '0);
        tick_fire  = tick_live && (cd_dec == '0);
        if (count_up_reg)
        begin
            phase_step = (phase_up > last_phase) ? '0 : phase_up;
        end
        else
        begin
            phase_step = (phase_reg == '0) ? last_phase : phase_reg - 1'b1;
        end
    end

    // Divider operands and quotient clamp
    always_comb
    begin
        spr_eff   = (spr_reg == '0) ? SPR_W'(1) : spr_reg;
        speed_eff = (cmd.speed == '0) ? SPEED_W'(1) : cmd.speed;
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        if (quo_reg[NUM_W-1:PERIOD_W] != '0)
        begin
            q_sat = '1;
        end
        else if (quo_reg[PERIOD_W-1:0] == '0)
        begin
            q_sat = PERIOD_W'(1);
        end
        else
        begin
            q_sat = quo_reg[PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        period_next   = period_reg;
        cd_next       = cd_reg;
        steps_next    = steps_reg;
        phase_next    = phase_reg;
        count_up_next = count_up_reg;
        coil_next     = coil_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        num_next      = num_reg;
        quo_next      = quo_reg;
        load_res      = 1'b0;
        stepped_now   = 1'b0;

        if (ctl.accept)
        begin
            unique case (cmd.op)
                OP_TICK:
                begin
                    load_res = 1'b1;
                    if (tick_live)
                    begin
                        cd_next = tick_fire ? period_reg : cd_dec;
                        if (tick_fire)
                        begin
                            stepped_now = 1'b1;
                            phase_next  = phase_step;
                            coil_next   = coil_lookup(mode_reg, phase_step, coil_reg);
                            steps_next  = steps_dec;
                            // drop the coils after the last step
                            if (steps_dec == '0)
                            begin
                                coil_next = COILS_OFF;
                            end
                        end
                    end
                end
                OP_START:
                begin
                    steps_next    = cmd.step_count;
                    count_up_next = !cmd.clockwise;
                    if (!cmd.clockwise)
                    begin
                        phase_next = PHASE_UP_START;
                    end
                    else
                    begin
                        phase_next = (mode_reg == MODE_HALF) ? PHASE_DOWN_EIGHT
                                                             : PHASE_DOWN_FOUR;
                    end
                    coil_next    = COILS_OFF;
                    divisor_next = spr_eff * speed_eff;
                    rem_next     = '0;
                    num_next     = PERIOD_NUM;
                    quo_next     = '0;
                end
                OP_STOP:
                begin
                    load_res   = 1'b1;
                    steps_next = '0;
                end
                default:
                begin
                    load_res = 1'b1;
                end
            endcase
        end

        // One restoring divide step per cycle, numerator bits from the top
        if (ctl.div_step)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, divisor_reg})
            begin
                rem_next = DIVISOR_W'(rem_shift - {1'b0, divisor_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end

        if (ctl.finish)
        begin
            period_next = q_sat;
            cd_next     = q_sat;
            load_res    = 1'b1;
        end

        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= DRIVE_MODE_RST;
            spr_reg       <= STEPS_PER_REV_RST;
            period_reg    <= '0;
            cd_reg        <= '0;
            steps_reg     <= '0;
            phase_reg     <= '0;
            count_up_reg  <= 1'b0;
            coil_reg      <= COILS_OFF;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_DRIVE_MODE:    mode_reg <= cfg.data[MODE_W-1:0];
                    REG_STEPS_PER_REV: spr_reg  <= cfg.data[SPR_W-1:0];
                    default:           spr_reg  <= spr_reg;
                endcase
            end
            period_reg    <= period_next;
            cd_reg        <= cd_next;
            steps_reg     <= steps_next;
            phase_reg     <= phase_next;
            count_up_reg  <= count_up_next;
            coil_reg      <= coil_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        if (load_res)
        begin
            res_coils_reg   <= coil_next;
            res_steps_reg   <= steps_next;
            res_stepped_reg <= stepped_now;
            res_busy_reg    <= (steps_next != '0);
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.coils      = res_coils_reg;
    assign res.steps_left = res_steps_reg;
    assign res.stepped    = res_stepped_reg;
    assign res.busy_res   = res_busy_reg;

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> period_reg != '0)
        else $error("period zero after start");

    a_step_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        (load_res && stepped_now) |=> cd_reg == period_reg)
        else $error("countdown not reloaded on step");

    a_last_step_off: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stepped_reg && !res_busy_reg) |-> res_coils_reg == COILS_OFF)
        else $error("coils left on after last step");

endmodule

`default_nettype wire
